/* src/lsd_pkg.sv */
// Shared types and constants for the per-object LRU stack distance block.
`timescale 1ns / 1ps

package lsd_pkg;

    localparam int NUM_OBJECTS = 64;
    localparam int MAX_DEPTH   = 16;

    localparam int OBJ_W   = 6;
    localparam int KEY_W   = 32;
    localparam int SIZE_W  = 5;
    localparam int DEPTH_W = 5;

    localparam int CNT_W  = $clog2(MAX_DEPTH + 1);
    localparam int POS_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int ROW_AW = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
    localparam int EXT_W  = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;

    localparam logic [SIZE_W-1:0] LIST_CAP_RESET = SIZE_W'(16);

    typedef logic [MAX_DEPTH-1:0][KEY_W-1:0] row_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        row_t             entries;
    } mem_word_t;

    typedef struct packed {
        logic               wr_en;
        logic [CNT_W-1:0]   count;
        row_t               entries;
        logic [DEPTH_W-1:0] depth;
    } upd_t;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

endpackage

/* src/lru_stack_distance_per_object.sv */
// Top level: per-object LRU stack distance with a row memory and an output register.
`timescale 1ns / 1ps

//  channel  direction  handshake          payload
//  s_       in         s_valid / s_ready  s_object_index[5:0], s_key_value[31:0]
//  m_       out        m_valid / m_ready  m_reuse_depth[4:0]
//  cfg_     in         cfg_we             cfg_wdata[4:0] (list capacity)
//
// For each beat, the accept edge reads the object's whole row (count and
// all keys) from the row memory into a register, and the write-back edge
// writes the updated row back and loads the result into the output register.
// Reset (aresetn low, synchronous) empties every list through the row valid
// bits at once and sets the list capacity to 16; no clearing pass is needed.
// A full output register stalls the write-back cycle; a new beat is taken
// as soon as the previous one has moved into the output register.

module lru_stack_distance_per_object (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lsd_pkg::OBJ_W-1:0]     s_object_index,
    input  logic [lsd_pkg::KEY_W-1:0]     s_key_value,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lsd_pkg::DEPTH_W-1:0]   m_reuse_depth,

    input  logic                          cfg_we,
    input  logic [lsd_pkg::SIZE_W-1:0]    cfg_wdata
);
    import lsd_pkg::*;

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   list_cap_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [ROW_AW-1:0]   addr_reg;
    logic                active_reg;
    logic                m_valid_reg, m_valid_next;
    logic [DEPTH_W-1:0]  m_depth_reg;

    logic                accept;
    logic                out_free;
    logic                done;
    logic [OBJ_W+ROW_AW-1:0] obj_ext;
    logic [ROW_AW-1:0]   rd_addr;
    logic                obj_ok;
    mem_word_t           rd_word;
    mem_word_t           wr_word;
    upd_t                upd;

    // Address the row of the incoming object; indexes past the last object
    // count as no access.
    assign obj_ext = {{ROW_AW{1'b0}}, s_object_index};
    assign rd_addr = obj_ext[ROW_AW-1:0];
    assign obj_ok  = (EXT_W + OBJ_W)'(s_object_index) < (EXT_W + OBJ_W)'(NUM_OBJECTS);

    lsd_row_mem u_row_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (done && upd.wr_en),
        .wr_addr (addr_reg),
        .wr_word (wr_word),
        .rd_word (rd_word)
    );

    lsd_row_update u_row_update (
        .rd_word    (rd_word),
        .key        (key_reg),
        .active     (active_reg),
        .list_cap   (list_cap_reg),
        .upd        (upd)
    );

    assign wr_word.count   = upd.count;
    assign wr_word.entries = upd.entries;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        accept   = s_valid && s_ready;
        out_free = !m_valid_reg || m_ready;
        done     = (state_reg == ST_UPDATE) && out_free;
    end

    // Load the output register on write-back, drop it once taken.
    always_comb begin
        priority if (done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            list_cap_reg <= LIST_CAP_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                list_cap_reg <= cfg_wdata;
            end
        end
    end

    // Hold the beat's key and object for the write-back cycle.
    always_ff @(posedge aclk) begin
        if (accept) begin
            key_reg    <= s_key_value;
            addr_reg   <= rd_addr;
            active_reg <= (s_key_value != '0) && obj_ok;
        end
        if (done) begin
            m_depth_reg <= upd.depth;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_reuse_depth = m_depth_reg;

endmodule

/* src/lsd_row_mem.sv */
// Row memory: one recency list and its count per object, with per-row valid bits.
`timescale 1ns / 1ps

module lsd_row_mem (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      rd_en,
    input  logic [lsd_pkg::ROW_AW-1:0] rd_addr,
    input  logic                      wr_en,
    input  logic [lsd_pkg::ROW_AW-1:0] wr_addr,
    input  lsd_pkg::mem_word_t        wr_word,
    output lsd_pkg::mem_word_t        rd_word
);
    import lsd_pkg::*;

    mem_word_t              mem [NUM_OBJECTS];
    logic [NUM_OBJECTS-1:0] row_valid_reg;
    mem_word_t              rd_word_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_word;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // a row never written reads as an empty list
    always_comb begin
        rd_word = rd_word_reg;
        if (!rd_valid_reg) begin
            rd_word.count = '0;
        end
    end

endmodule

/* src/lsd_row_update.sv */
// Row update: parallel key search, move-to-front shift and reuse depth.
`timescale 1ns / 1ps

module lsd_row_update (
    input  lsd_pkg::mem_word_t             rd_word,
    input  logic [lsd_pkg::KEY_W-1:0]      key,
    input  logic                           active,
    input  logic [lsd_pkg::SIZE_W-1:0]     list_cap,
    output lsd_pkg::upd_t                  upd
);
    import lsd_pkg::*;

    logic [CNT_W-1:0]     n;
    logic [EXT_W-1:0]     eff;
    logic [EXT_W-1:0]     n_plus;
    logic [CNT_W-1:0]     new_count;
    logic [MAX_DEPTH-1:0] hit;
    logic                 hit_any;
    logic [POS_W-1:0]     pos;
    logic [CNT_W-1:0]     lim;
    logic [EXT_W-1:0]     depth_ext;

    always_comb begin
        n = (EXT_W'(rd_word.count) > EXT_W'(MAX_DEPTH)) ? CNT_W'(MAX_DEPTH) : rd_word.count;
        eff = (EXT_W'(list_cap) > EXT_W'(MAX_DEPTH)) ? EXT_W'(MAX_DEPTH)
                                                     : EXT_W'(list_cap);

        for (int i = 0; i < MAX_DEPTH; i++) begin
            hit[i] = (CNT_W'(i) < n) && (rd_word.entries[i] == key);
        end
        hit_any = |hit;

        // first match from the front wins
        pos = '0;
        for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
            if (hit[i]) begin
                pos = POS_W'(i);
            end
        end

        // drop the last entry when the list would overflow
        n_plus    = EXT_W'(n) + EXT_W'(1);
        new_count = (n_plus > eff) ? n : CNT_W'(n_plus);

        lim = hit_any ? (CNT_W'(pos) + CNT_W'(1)) : new_count;

        upd.entries[0] = (lim != '0) ? key : rd_word.entries[0];
        for (int j = 1; j < MAX_DEPTH; j++) begin
            upd.entries[j] = (CNT_W'(j) < lim) ? rd_word.entries[j-1] : rd_word.entries[j];
        end

        upd.count = hit_any ? rd_word.count : new_count;
        upd.wr_en = active;

        depth_ext = hit_any ? (EXT_W'(pos) + EXT_W'(1)) : (eff + EXT_W'(1));
        upd.depth = active ? depth_ext[DEPTH_W-1:0] : '0;
    end

endmodule

/* verif/lru_stack_distance_per_object_test.sv */
// Self-checking testbench for the per-object LRU stack distance block.
`timescale 1ns / 1ps

module lru_stack_distance_per_object_test;
    import lsd_pkg::*;

    typedef struct {
        logic [OBJ_W-1:0] obj;
        logic [KEY_W-1:0] key;
    } access_t;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [OBJ_W-1:0]   s_object_index = '0;
    logic [KEY_W-1:0]   s_key_value    = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [DEPTH_W-1:0] m_reuse_depth;
    logic               cfg_we         = 1'b0;
    logic [SIZE_W-1:0]  cfg_wdata      = '0;

    // Beats waiting to be offered, and depths owed by the block in order.
    access_t            pending_accesses[$];
    logic [DEPTH_W-1:0] depth_due[$];

    // Shadow copy of the recency lists, their counts and the list capacity.
    logic [KEY_W-1:0]   lru_keys[NUM_OBJECTS][MAX_DEPTH];
    int unsigned        lru_counts[NUM_OBJECTS];
    int unsigned        list_cap_shadow = 16;

    int                 errors       = 0;
    int                 results_seen = 0;
    bit                 steady       = 1'b0;  // no idling on either side
    int                 send_gap     = 0;
    int                 take_stall   = 0;
    int                 take_hold    = 0;

    lru_stack_distance_per_object dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_object_index (s_object_index),
        .s_key_value    (s_key_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_reuse_depth  (m_reuse_depth),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Apply one access to the shadow lists and return the reuse depth it yields.
    function automatic logic [DEPTH_W-1:0] lru_access(input logic [OBJ_W-1:0] obj,
                                                      input logic [KEY_W-1:0] key);
        int unsigned cap;
        int unsigned n;
        int unsigned pos;
        int unsigned j;
        bit          found;
        if (key == '0) begin
            return '0;
        end
        // Clamp the capacity to the physical depth, for capacity and miss answer.
        cap = (list_cap_shadow > MAX_DEPTH) ? MAX_DEPTH : list_cap_shadow;
        n   = lru_counts[obj];
        if (n > MAX_DEPTH) begin
            n = MAX_DEPTH;
        end
        found = 1'b0;
        pos   = n;
        for (j = 0; j < n; j++) begin
            if (!found && lru_keys[obj][j] == key) begin
                found = 1'b1;
                pos   = j;
            end
        end
        if (found) begin
            // Hit: move the key to the front, answer its true position.
            for (j = pos; j > 0; j--) begin
                lru_keys[obj][j] = lru_keys[obj][j-1];
            end
            lru_keys[obj][0] = key;
            return DEPTH_W'(pos + 1);
        end
        // Miss: insert at the front, drop only the last entry on overflow.
        n = n + 1;
        if (n > cap) begin
            n = n - 1;
        end
        if (n > 0) begin
            for (j = n - 1; j > 0; j--) begin
                lru_keys[obj][j] = lru_keys[obj][j-1];
            end
            lru_keys[obj][0] = key;
        end
        lru_counts[obj] = n;
        return DEPTH_W'(cap + 1);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic queue_access(input logic [OBJ_W-1:0] obj, input logic [KEY_W-1:0] key);
        access_t a;
        a.obj = obj;
        a.key = key;
        pending_accesses.insert(pending_accesses.size(), a);
    endtask

    // Wait until the block is drained, then write the capacity and pick the idling mode.
    task automatic start_phase(input logic [SIZE_W-1:0] size, input bit no_idle);
        while (pending_accesses.size() > 0 || s_valid || depth_due.size() > 0) begin
            @(posedge aclk);
        end
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge aclk);
        cfg_we          <= 1'b0;
        list_cap_shadow = size;
        steady          = no_idle;
    endtask

    // Mostly a few busy objects and a small key pool so lists fill and hits occur;
    // the rest is zero keys, any object and fully random keys.
    task automatic queue_random_accesses(input int count);
        logic [KEY_W-1:0] key_pool[20];
        logic [OBJ_W-1:0] busy_obj[3];
        logic [OBJ_W-1:0] obj;
        logic [KEY_W-1:0] key;
        int               r;
        for (int i = 0; i < 20; i++) begin
            key_pool[i] = $urandom;
            if (key_pool[i] == '0) begin
                key_pool[i] = 32'h1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            busy_obj[i] = $urandom_range(0, NUM_OBJECTS - 1);
        end
        for (int i = 0; i < count; i++) begin
            obj = ($urandom_range(0, 99) < 80) ? busy_obj[$urandom_range(0, 2)]
                                                : OBJ_W'($urandom_range(0, NUM_OBJECTS - 1));
            r   = $urandom_range(0, 99);
            if (r < 8) begin
                key = '0;
            end else if (r < 75) begin
                key = key_pool[$urandom_range(0, 19)];
            end else begin
                key = $urandom;
            end
            queue_access(obj, key);
        end
    endtask

    // Driver: predict on every accepted beat, hold a beat until it is taken,
    // then idle for the drawn gap before offering the next one.
    always @(posedge aclk) begin : drive_beats
        access_t nxt;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                depth_due.insert(depth_due.size(), lru_access(s_object_index, s_key_value));
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    s_valid  <= 1'b0;
                    send_gap--;
                end else if (pending_accesses.size() > 0) begin
                    nxt            = pending_accesses.pop_front();
                    s_valid        <= 1'b1;
                    s_object_index <= nxt.obj;
                    s_key_value    <= nxt.key;
                    send_gap       = steady ? 0 : $urandom_range(0, 4);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each taken beat against the oldest owed depth, then stall.
    // Once, hold off for a long stretch so the block backs up into its input.
    always @(posedge aclk) begin : take_results
        logic [DEPTH_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (depth_due.size() == 0) begin
                report_mismatch($sformatf("reuse_depth %0d with no access owed", m_reuse_depth));
            end else begin
                want = depth_due.pop_front();
                if (m_reuse_depth !== want) begin
                    report_mismatch($sformatf("reuse_depth got %0d want %0d",
                                              m_reuse_depth, want));
                end
            end
            results_seen++;
            take_stall = steady ? 0 : $urandom_range(0, 4);
            if (results_seen == 200) begin
                take_hold = 80;
            end
        end
        if (take_hold > 0) begin
            take_hold--;
            m_ready <= 1'b0;
        end else if (take_stall > 0) begin
            take_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn;
        end
    end

    initial begin
        int sizes[9];
        int drain;
        sizes = '{16, 31, 0, 1, 5, 17, 3, 16, 2};
        for (int o = 0; o < NUM_OBJECTS; o++) begin
            lru_counts[o] = 0;
            for (int d = 0; d < MAX_DEPTH; d++) begin
                lru_keys[o][d] = '0;
            end
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset capacity, zero keys, all-ones and single-bit keys, a deep list.
        queue_access(6'd0, 32'h0);
        queue_access(6'd63, 32'hFFFF_FFFF);
        queue_access(6'd63, 32'hFFFF_FFFF);
        queue_access(6'd63, 32'h0000_0001);
        queue_access(6'd63, 32'hFFFF_FFFF);
        queue_access(6'd0, 32'h8000_0000);
        for (int k = 10; k < 15; k++) begin
            queue_access(6'd9, KEY_W'(k));
        end
        queue_access(6'd9, 32'd10);

        // Lower the capacity below the count: deep hit keeps its true position,
        // a miss drops only the last entry.
        start_phase(5'd2, 1'b0);
        queue_access(6'd9, 32'd11);
        queue_access(6'd9, 32'd99);
        queue_access(6'd2, 32'd5);
        queue_access(6'd2, 32'd6);
        queue_access(6'd2, 32'd7);

        // Capacity zero: fresh keys always miss with depth one and are not kept.
        start_phase(5'd0, 1'b0);
        queue_access(6'd5, 32'd7);
        queue_access(6'd5, 32'd7);
        queue_access(6'd63, 32'hFFFF_FFFF);

        // Capacity above the physical depth saturates.
        start_phase(5'd31, 1'b1);
        queue_access(6'd5, 32'd8);
        queue_access(6'd5, 32'd8);
        queue_access(6'd63, 32'h0);

        // Random phases across several capacities, every third one without idling.
        foreach (sizes[p]) begin
            start_phase(SIZE_W'(sizes[p]), (p % 3) == 2);
            queue_random_accesses(103);
        end

        // Let every beat go out, then give the block time to deliver the rest.
        while (pending_accesses.size() > 0 || s_valid) begin
            @(posedge aclk);
        end
        drain = 0;
        while (depth_due.size() > 0 && drain < 500) begin
            @(posedge aclk);
            drain++;
        end
        repeat (4) @(posedge aclk);
        if (depth_due.size() != 0) begin
            report_mismatch($sformatf("%0d reuse depths never delivered", depth_due.size()));
        end
        if (errors == 0) begin
            $display("[lru_stack_distance_per_object] OK");
        end else begin
            $display("[lru_stack_distance_per_object] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #400000;
        $display("[lru_stack_distance_per_object] ERROR");
        $finish;
    end

endmodule
